### rtl/slts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slts_pkg
// Shared widths, token kind codes, character classes and status types for
// the source lexer token scanner.
// ----------------------------------------------------------------------------
package slts_pkg;

  localparam int KIND_W = 5;
  localparam int MAX_TOK = 4;
  localparam int TIDX_W = $clog2(MAX_TOK);
  localparam int CNT_W = $clog2(MAX_TOK + 1);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [KIND_W-1:0] K_LPAREN     = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAREN     = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACE     = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACE     = 5'd3;
  localparam logic [KIND_W-1:0] K_COMMA      = 5'd4;
  localparam logic [KIND_W-1:0] K_DOT        = 5'd5;
  localparam logic [KIND_W-1:0] K_MINUS      = 5'd6;
  localparam logic [KIND_W-1:0] K_PLUS       = 5'd7;
  localparam logic [KIND_W-1:0] K_SEMICOLON  = 5'd8;
  localparam logic [KIND_W-1:0] K_SLASH      = 5'd9;
  localparam logic [KIND_W-1:0] K_STAR       = 5'd10;
  localparam logic [KIND_W-1:0] K_BANG       = 5'd11;
  localparam logic [KIND_W-1:0] K_BANG_EQ    = 5'd12;
  localparam logic [KIND_W-1:0] K_EQ         = 5'd13;
  localparam logic [KIND_W-1:0] K_EQ_EQ      = 5'd14;
  localparam logic [KIND_W-1:0] K_GT         = 5'd15;
  localparam logic [KIND_W-1:0] K_GT_EQ      = 5'd16;
  localparam logic [KIND_W-1:0] K_LT         = 5'd17;
  localparam logic [KIND_W-1:0] K_LT_EQ      = 5'd18;
  localparam logic [KIND_W-1:0] K_IDENT      = 5'd19;
  localparam logic [KIND_W-1:0] K_STRING     = 5'd20;
  localparam logic [KIND_W-1:0] K_NUMBER     = 5'd21;
  localparam logic [KIND_W-1:0] K_END        = 5'd22;
  localparam logic [KIND_W-1:0] K_BAD        = 5'd23;
  localparam logic [KIND_W-1:0] K_UNTERM     = 5'd24;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic empty;
    logic full;
  } slts_qstat_t;

  function automatic int grp_width(int pw, int lw);
    return MAX_TOK * (KIND_W + 2 * pw + lw) + TIDX_W;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return c inside {"(", ")", "{", "}", ",", ".", "-", "+", ";", "*"};
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ",": k = K_COMMA;
      ".": k = K_DOT;
      "-": k = K_MINUS;
      "+": k = K_PLUS;
      ";": k = K_SEMICOLON;
      "*": k = K_STAR;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

endpackage

### rtl/slts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slts_front
// Scanner front end: takes one source byte a cycle unless the queue is full,
// steps the scan mode and counters, and packs its tokens into one queue word.
// ----------------------------------------------------------------------------
module slts_front #(
  parameter int POS_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                char_byte,
  input  logic                      has_byte,
  input  logic                      end_of_source,
  input  logic                      byte_valid,
  output logic                      byte_ready,
  input  slts_pkg::slts_qstat_t     qstat,
  output logic                      push,
  output logic [slts_pkg::grp_width(POS_WIDTH, LINE_WIDTH)-1:0] push_data
);
  import slts_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [POS_WIDTH-1:0]  start;
    logic [POS_WIDTH-1:0]  len;
    logic [LINE_WIDTH-1:0] line;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOK-1:0] toks;
    logic [TIDX_W-1:0]  last;
  } grp_t;

  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_BANG     = 4'd1;
  localparam logic [3:0] M_EQ       = 4'd2;
  localparam logic [3:0] M_GT       = 4'd3;
  localparam logic [3:0] M_LT       = 4'd4;
  localparam logic [3:0] M_SLASH    = 4'd5;
  localparam logic [3:0] M_COMMENT  = 4'd6;
  localparam logic [3:0] M_STRING   = 4'd7;
  localparam logic [3:0] M_IDENT    = 4'd8;
  localparam logic [3:0] M_NUM_INT  = 4'd9;
  localparam logic [3:0] M_NUM_DOT  = 4'd10;
  localparam logic [3:0] M_NUM_FRAC = 4'd11;

  localparam logic [POS_WIDTH-1:0]  POS_ONE  = POS_WIDTH'(1);
  localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

  function automatic tok_t mk_tok(logic [KIND_W-1:0] k, logic [POS_WIDTH-1:0] s,
                                  logic [POS_WIDTH-1:0] l, logic [LINE_WIDTH-1:0] ln);
    tok_t t;
    t.kind = k;
    t.start = s;
    t.len = l;
    t.line = ln;
    return t;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(logic [3:0] m);
    logic [KIND_W-1:0] k;
    case (m)
      M_BANG:  k = K_BANG;
      M_EQ:    k = K_EQ;
      M_GT:    k = K_GT;
      default: k = K_LT;
    endcase
    return k;
  endfunction

  logic [3:0]            mode, mode_next;
  logic [POS_WIDTH-1:0]  lex_start, lex_start_next;
  logic [POS_WIDTH-1:0]  pos, pos_next;
  logic [LINE_WIDTH-1:0] line, line_next;

  logic [POS_WIDTH-1:0]  end_pos;
  logic [POS_WIDTH-1:0]  len1;
  logic [POS_WIDTH-1:0]  dot_pos;
  logic [POS_WIDTH-1:0]  fdot_pos;
  logic                  run_idle;
  logic [CNT_W-1:0]      n;
  tok_t [MAX_TOK-1:0]    toks;
  grp_t                  grp;
  logic                  accept;

  assign byte_ready = !qstat.full;
  assign accept = byte_valid && byte_ready;

  assign end_pos = (pos == '1) ? pos : pos + POS_ONE;
  assign len1 = end_pos - pos;
  assign dot_pos = pos - POS_ONE;

  always_comb begin
    mode_next = mode;
    lex_start_next = lex_start;
    pos_next = pos;
    line_next = line;
    toks = '0;
    n = '0;
    run_idle = 1'b0;
    fdot_pos = '0;

    if (has_byte) begin
      pos_next = end_pos;
      case (mode)
        M_BANG, M_EQ, M_GT, M_LT: begin
          if (char_byte == "=") begin
            toks[n[TIDX_W-1:0]] = mk_tok(op_kind(mode) + KIND_W'(1), lex_start,
                                         end_pos - lex_start, line);
            n = n + CNT_W'(1);
            mode_next = M_IDLE;
          end else begin
            toks[n[TIDX_W-1:0]] = mk_tok(op_kind(mode), lex_start, pos - lex_start, line);
            n = n + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_SLASH: begin
          if (char_byte == "/") begin
            mode_next = M_COMMENT;
          end else begin
            toks[n[TIDX_W-1:0]] = mk_tok(K_SLASH, lex_start, pos - lex_start, line);
            n = n + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (char_byte == CH_LF) run_idle = 1'b1;
        end
        M_STRING: begin
          if (char_byte == CH_QUOTE) begin
            toks[n[TIDX_W-1:0]] = mk_tok(K_STRING, lex_start, end_pos - lex_start, line);
            n = n + CNT_W'(1);
            mode_next = M_IDLE;
          end else if (char_byte == CH_LF && line != '1) begin
            line_next = line + LINE_ONE;
          end
        end
        M_IDENT: begin
          if (!(is_alpha(char_byte) || is_digit(char_byte))) begin
            toks[n[TIDX_W-1:0]] = mk_tok(K_IDENT, lex_start, pos - lex_start, line);
            n = n + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_NUM_INT: begin
          if (char_byte == ".") begin
            mode_next = M_NUM_DOT;
          end else if (!is_digit(char_byte)) begin
            toks[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, lex_start, pos - lex_start, line);
            n = n + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_NUM_DOT: begin
          if (is_digit(char_byte)) begin
            mode_next = M_NUM_FRAC;
          end else begin
            toks[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, lex_start, dot_pos - lex_start, line);
            n = n + CNT_W'(1);
            toks[n[TIDX_W-1:0]] = mk_tok(K_DOT, dot_pos, POS_ONE, line);
            n = n + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_NUM_FRAC: begin
          if (!is_digit(char_byte)) begin
            toks[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, lex_start, pos - lex_start, line);
            n = n + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      if (run_idle) begin
        mode_next = M_IDLE;
        if (is_single(char_byte)) begin
          toks[n[TIDX_W-1:0]] = mk_tok(single_kind(char_byte), pos, len1, line);
          n = n + CNT_W'(1);
        end else begin
          case (char_byte)
            "!": begin
              mode_next = M_BANG;
              lex_start_next = pos;
            end
            "=": begin
              mode_next = M_EQ;
              lex_start_next = pos;
            end
            ">": begin
              mode_next = M_GT;
              lex_start_next = pos;
            end
            "<": begin
              mode_next = M_LT;
              lex_start_next = pos;
            end
            "/": begin
              mode_next = M_SLASH;
              lex_start_next = pos;
            end
            CH_QUOTE: begin
              mode_next = M_STRING;
              lex_start_next = pos;
            end
            CH_SPACE, CH_CR, CH_TAB: begin
            end
            CH_LF: begin
              if (line != '1) line_next = line + LINE_ONE;
            end
            default: begin
              if (is_digit(char_byte)) begin
                mode_next = M_NUM_INT;
                lex_start_next = pos;
              end else if (is_alpha(char_byte)) begin
                mode_next = M_IDENT;
                lex_start_next = pos;
              end else begin
                toks[n[TIDX_W-1:0]] = mk_tok(K_BAD, pos, len1, line);
                n = n + CNT_W'(1);
              end
            end
          endcase
        end
      end
    end

    if (end_of_source) begin
      fdot_pos = pos_next - POS_ONE;
      case (mode_next)
        M_BANG, M_EQ, M_GT, M_LT: begin
          toks[n[TIDX_W-1:0]] = mk_tok(op_kind(mode_next), lex_start_next,
                                       pos_next - lex_start_next, line_next);
          n = n + CNT_W'(1);
        end
        M_SLASH: begin
          toks[n[TIDX_W-1:0]] = mk_tok(K_SLASH, lex_start_next,
                                       pos_next - lex_start_next, line_next);
          n = n + CNT_W'(1);
        end
        M_STRING: begin
          toks[n[TIDX_W-1:0]] = mk_tok(K_UNTERM, lex_start_next,
                                       pos_next - lex_start_next, line_next);
          n = n + CNT_W'(1);
        end
        M_IDENT: begin
          toks[n[TIDX_W-1:0]] = mk_tok(K_IDENT, lex_start_next,
                                       pos_next - lex_start_next, line_next);
          n = n + CNT_W'(1);
        end
        M_NUM_INT, M_NUM_FRAC: begin
          toks[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, lex_start_next,
                                       pos_next - lex_start_next, line_next);
          n = n + CNT_W'(1);
        end
        M_NUM_DOT: begin
          toks[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, lex_start_next,
                                       fdot_pos - lex_start_next, line_next);
          n = n + CNT_W'(1);
          toks[n[TIDX_W-1:0]] = mk_tok(K_DOT, fdot_pos, POS_ONE, line_next);
          n = n + CNT_W'(1);
        end
        default: begin
        end
      endcase
      toks[n[TIDX_W-1:0]] = mk_tok(K_END, pos_next, '0, line_next);
      n = n + CNT_W'(1);
      mode_next = M_IDLE;
      lex_start_next = '0;
      pos_next = '0;
      line_next = LINE_ONE;
    end
  end

  assign grp.toks = toks;
  assign grp.last = TIDX_W'(n - CNT_W'(1));
  assign push = accept && (n != '0);
  assign push_data = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      lex_start <= '0;
      pos <= '0;
      line <= LINE_ONE;
    end else if (accept) begin
      mode <= mode_next;
      lex_start <= lex_start_next;
      pos <= pos_next;
      line <= line_next;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst) line != '0)
    else $error("line count reached zero");

endmodule

### rtl/slts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slts_queue
// Short queue of token groups between the scanner and the token serialiser.
// ----------------------------------------------------------------------------
module slts_queue #(
  parameter int POS_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [slts_pkg::grp_width(POS_WIDTH, LINE_WIDTH)-1:0] push_data,
  input  logic                  pop,
  output logic [slts_pkg::grp_width(POS_WIDTH, LINE_WIDTH)-1:0] head_data,
  output slts_pkg::slts_qstat_t qstat
);
  import slts_pkg::*;

  localparam int GRP_W = grp_width(POS_WIDTH, LINE_WIDTH);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [GRP_W-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qstat.empty = (count == '0);
  assign qstat.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

### rtl/slts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slts_back
// Token serialiser: walks the head group of the queue one token per word and
// releases the group after its last token.
// ----------------------------------------------------------------------------
module slts_back #(
  parameter int POS_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [slts_pkg::grp_width(POS_WIDTH, LINE_WIDTH)-1:0] head_data,
  input  slts_pkg::slts_qstat_t  qstat,
  output logic                   pop,
  output logic                   token_valid,
  input  logic                   token_ready,
  output logic [slts_pkg::KIND_W-1:0] token_kind,
  output logic [POS_WIDTH-1:0]   token_start,
  output logic [POS_WIDTH-1:0]   token_length,
  output logic [LINE_WIDTH-1:0]  token_line,
  output logic                   last_of_run
);
  import slts_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [POS_WIDTH-1:0]  start;
    logic [POS_WIDTH-1:0]  len;
    logic [LINE_WIDTH-1:0] line;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOK-1:0] toks;
    logic [TIDX_W-1:0]  last;
  } grp_t;

  grp_t              head;
  tok_t              cur;
  logic [TIDX_W-1:0] idx;
  logic              taken;

  assign head = head_data;
  assign cur = head.toks[idx];

  assign token_valid = !qstat.empty;
  assign token_kind = cur.kind;
  assign token_start = cur.start;
  assign token_length = cur.len;
  assign token_line = cur.line;
  assign last_of_run = (idx == head.last);

  assign taken = token_valid && token_ready;
  assign pop = taken && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (taken) begin
      if (last_of_run) idx <= '0;
      else idx <= idx + TIDX_W'(1);
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
                                   token_valid |-> idx <= head.last)
    else $error("token index beyond group");
  a_idx_idle_zero: assert property (@(posedge clk) disable iff (rst)
                                    !token_valid |-> idx == '0)
    else $error("token index held without a group");

endmodule

### rtl/source_lexer_token_scanner_unit.sv
`timescale 1ns / 1ps
// Tokens completed by a byte are written into the group queue and leave from its head slot.
// Throughput: one byte per cycle while the four-group queue has room.
// Tokens leave one per cycle while token_ready is high; a byte yields up to four tokens.
// Output drain (one token per cycle) sets the sustained rate for token-dense text.
// Reset: synchronous; scanner idle, position zero, line one, queue empty.
// ----------------------------------------------------------------------------
// source_lexer_token_scanner_unit
// Streaming maximal-munch lexical scanner: scanner front end, group queue and
// token serialiser.
// ----------------------------------------------------------------------------
module source_lexer_token_scanner_unit #(
  parameter int POS_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  logic [7:0]                  char_byte,
  input  logic                        has_byte,
  input  logic                        end_of_source,
  output logic                        token_valid,
  input  logic                        token_ready,
  output logic [slts_pkg::KIND_W-1:0] token_kind,
  output logic [POS_WIDTH-1:0]        token_start,
  output logic [POS_WIDTH-1:0]        token_length,
  output logic [LINE_WIDTH-1:0]       token_line,
  output logic                        last_of_run
);
  import slts_pkg::*;

  localparam int GRP_W = grp_width(POS_WIDTH, LINE_WIDTH);

  slts_qstat_t      qstat;
  logic             push;
  logic             pop;
  logic [GRP_W-1:0] push_data;
  logic [GRP_W-1:0] head_data;

  slts_front #(
    .POS_WIDTH(POS_WIDTH),
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .char_byte(char_byte),
    .has_byte(has_byte),
    .end_of_source(end_of_source),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .qstat(qstat),
    .push(push),
    .push_data(push_data)
  );

  slts_queue #(
    .POS_WIDTH(POS_WIDTH),
    .LINE_WIDTH(LINE_WIDTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(pop),
    .head_data(head_data),
    .qstat(qstat)
  );

  slts_back #(
    .POS_WIDTH(POS_WIDTH),
    .LINE_WIDTH(LINE_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head_data(head_data),
    .qstat(qstat),
    .pop(pop),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .token_line(token_line),
    .last_of_run(last_of_run)
  );

endmodule

### verif/lexer_token_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer_token_monitor
// Watches the byte and token channels of the scanner. Every accepted byte
// word is run through a local maximal-munch scanner that predicts the tokens
// it completes; every accepted token is compared field by field, in order,
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module lexer_token_monitor #(
  parameter int POS_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  input  logic                        byte_ready,
  input  logic [7:0]                  char_byte,
  input  logic                        has_byte,
  input  logic                        end_of_source,
  input  logic                        token_valid,
  input  logic                        token_ready,
  input  logic [slts_pkg::KIND_W-1:0] token_kind,
  input  logic [POS_WIDTH-1:0]        token_start,
  input  logic [POS_WIDTH-1:0]        token_length,
  input  logic [LINE_WIDTH-1:0]       token_line,
  input  logic                        last_of_run,
  output int                          mismatch_count,
  output int                          tokens_pending
);
  import slts_pkg::*;

  localparam logic [POS_WIDTH-1:0]  POS_TOP  = {POS_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0] LINE_TOP = {LINE_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    LX_IDLE, LX_BANG, LX_EQ, LX_GT, LX_LT, LX_SLASH, LX_COMMENT,
    LX_STRING, LX_IDENT, LX_INT, LX_DOT, LX_FRAC
  } lex_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [POS_WIDTH-1:0]  start;
    logic [POS_WIDTH-1:0]  len;
    logic [LINE_WIDTH-1:0] line_no;
    logic                  last_mark;
  } token_t;

  lex_mode_e             mode;
  logic [POS_WIDTH-1:0]  lex_start;
  logic [POS_WIDTH-1:0]  next_pos;
  logic [LINE_WIDTH-1:0] line_no;
  token_t                run_q[$];
  token_t                tokens_due[$];
  int                    errors;

  function automatic logic [POS_WIDTH-1:0] bump_pos(input logic [POS_WIDTH-1:0] p);
    return (p == POS_TOP) ? p : p + 1'b1;
  endfunction

  function automatic logic [POS_WIDTH-1:0] span(input logic [POS_WIDTH-1:0] a,
                                                input logic [POS_WIDTH-1:0] b);
    return b - a;
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void reset_scan();
    mode = LX_IDLE;
    lex_start = '0;
    next_pos = '0;
    line_no = LINE_WIDTH'(1);
  endfunction

  function automatic void bump_line();
    if (line_no != LINE_TOP) line_no = line_no + 1'b1;
  endfunction

  function automatic void push_token(input logic [KIND_W-1:0] kind,
                                     input logic [POS_WIDTH-1:0] start,
                                     input logic [POS_WIDTH-1:0] len);
    token_t t;
    if (run_q.size() < MAX_TOK) begin
      t.kind = kind;
      t.start = start;
      t.len = len;
      t.line_no = line_no;
      t.last_mark = 1'b0;
      run_q.push_back(t);
    end
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(input lex_mode_e m, input logic with_eq);
    case (m)
      LX_BANG: return with_eq ? K_BANG_EQ : K_BANG;
      LX_EQ:   return with_eq ? K_EQ_EQ : K_EQ;
      LX_GT:   return with_eq ? K_GT_EQ : K_GT;
      default: return with_eq ? K_LT_EQ : K_LT;
    endcase
  endfunction

  function automatic void start_lexeme(input logic [7:0] c, input logic [POS_WIDTH-1:0] p);
    logic [POS_WIDTH-1:0] len1;
    len1 = span(p, bump_pos(p));
    mode = LX_IDLE;
    case (c)
      "(": push_token(K_LPAREN, p, len1);
      ")": push_token(K_RPAREN, p, len1);
      "{": push_token(K_LBRACE, p, len1);
      "}": push_token(K_RBRACE, p, len1);
      ",": push_token(K_COMMA, p, len1);
      ".": push_token(K_DOT, p, len1);
      "-": push_token(K_MINUS, p, len1);
      "+": push_token(K_PLUS, p, len1);
      ";": push_token(K_SEMICOLON, p, len1);
      "*": push_token(K_STAR, p, len1);
      "!": begin mode = LX_BANG; lex_start = p; end
      "=": begin mode = LX_EQ; lex_start = p; end
      ">": begin mode = LX_GT; lex_start = p; end
      "<": begin mode = LX_LT; lex_start = p; end
      "/": begin mode = LX_SLASH; lex_start = p; end
      CH_QUOTE: begin mode = LX_STRING; lex_start = p; end
      CH_SPACE, CH_CR, CH_TAB: ;
      CH_LF: bump_line();
      default: begin
        if (digit_ch(c)) begin
          mode = LX_INT;
          lex_start = p;
        end else if (alpha_ch(c)) begin
          mode = LX_IDENT;
          lex_start = p;
        end else begin
          push_token(K_BAD, p, len1);
        end
      end
    endcase
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic [POS_WIDTH-1:0] p;
    logic [POS_WIDTH-1:0] stop;
    logic [POS_WIDTH-1:0] dot_at;
    p = next_pos;
    stop = bump_pos(p);
    case (mode)
      LX_BANG, LX_EQ, LX_GT, LX_LT: begin
        if (c == "=") begin
          push_token(pair_kind(mode, 1'b1), lex_start, span(lex_start, stop));
          mode = LX_IDLE;
        end else begin
          push_token(pair_kind(mode, 1'b0), lex_start, span(lex_start, p));
          start_lexeme(c, p);
        end
      end
      LX_SLASH: begin
        if (c == "/") begin
          mode = LX_COMMENT;
        end else begin
          push_token(K_SLASH, lex_start, span(lex_start, p));
          start_lexeme(c, p);
        end
      end
      LX_COMMENT: begin
        if (c == CH_LF) start_lexeme(c, p);
      end
      LX_STRING: begin
        if (c == CH_QUOTE) begin
          push_token(K_STRING, lex_start, span(lex_start, stop));
          mode = LX_IDLE;
        end else if (c == CH_LF) begin
          bump_line();
        end
      end
      LX_IDENT: begin
        if (!(alpha_ch(c) || digit_ch(c))) begin
          push_token(K_IDENT, lex_start, span(lex_start, p));
          start_lexeme(c, p);
        end
      end
      LX_INT: begin
        if (c == ".") begin
          mode = LX_DOT;
        end else if (!digit_ch(c)) begin
          push_token(K_NUMBER, lex_start, span(lex_start, p));
          start_lexeme(c, p);
        end
      end
      LX_DOT: begin
        if (digit_ch(c)) begin
          mode = LX_FRAC;
        end else begin
          dot_at = p - 1'b1;
          push_token(K_NUMBER, lex_start, span(lex_start, dot_at));
          push_token(K_DOT, dot_at, POS_WIDTH'(1));
          start_lexeme(c, p);
        end
      end
      LX_FRAC: begin
        if (!digit_ch(c)) begin
          push_token(K_NUMBER, lex_start, span(lex_start, p));
          start_lexeme(c, p);
        end
      end
      default: start_lexeme(c, p);
    endcase
    next_pos = stop;
  endfunction

  function automatic void close_source();
    logic [POS_WIDTH-1:0] dot_at;
    case (mode)
      LX_BANG, LX_EQ, LX_GT, LX_LT:
        push_token(pair_kind(mode, 1'b0), lex_start, span(lex_start, next_pos));
      LX_SLASH:  push_token(K_SLASH, lex_start, span(lex_start, next_pos));
      LX_STRING: push_token(K_UNTERM, lex_start, span(lex_start, next_pos));
      LX_IDENT:  push_token(K_IDENT, lex_start, span(lex_start, next_pos));
      LX_INT, LX_FRAC: push_token(K_NUMBER, lex_start, span(lex_start, next_pos));
      LX_DOT: begin
        dot_at = next_pos - 1'b1;
        push_token(K_NUMBER, lex_start, span(lex_start, dot_at));
        push_token(K_DOT, dot_at, POS_WIDTH'(1));
      end
      default: ;
    endcase
    push_token(K_END, next_pos, '0);
    reset_scan();
  endfunction

  function automatic void predict_word(input logic [7:0] c, input logic hb, input logic eos);
    token_t t;
    run_q.delete();
    if (hb) scan_char(c);
    if (eos) close_source();
    if (run_q.size() > 0) begin
      t = run_q.pop_back();
      t.last_mark = 1'b1;
      run_q.push_back(t);
    end
    foreach (run_q[i]) tokens_due.push_back(run_q[i]);
  endfunction

  initial reset_scan();

  always @(posedge clk) begin : watch
    token_t want;
    if (rst) begin
      reset_scan();
      tokens_due.delete();
    end else begin
      if (byte_valid && byte_ready) predict_word(char_byte, has_byte, end_of_source);
      if (token_valid && token_ready) begin
        if (tokens_due.size() == 0) begin
          $error("token with nothing pending: token_kind %0d token_start %0d",
                 token_kind, token_start);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          if (token_kind !== want.kind) begin
            $error("token_kind expected %0d got %0d", want.kind, token_kind);
            errors++;
          end
          if (token_start !== want.start) begin
            $error("token_start expected %0d got %0d", want.start, token_start);
            errors++;
          end
          if (token_length !== want.len) begin
            $error("token_length expected %0d got %0d", want.len, token_length);
            errors++;
          end
          if (token_line !== want.line_no) begin
            $error("token_line expected %0d got %0d", want.line_no, token_line);
            errors++;
          end
          if (last_of_run !== want.last_mark) begin
            $error("last_of_run expected %0d got %0d", want.last_mark, last_of_run);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    tokens_pending <= tokens_due.size();
  end

endmodule

### verif/tb_source_lexer_token_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_lexer_token_scanner_unit
// Drives source text into the scanner in random bursts while the token side
// stalls on its own pattern: a directed pass over every operator and special
// case, then random sources built from well-formed lexemes mixed with noise.
// The monitor checks tokens.
// ----------------------------------------------------------------------------
module tb_source_lexer_token_scanner_unit;
  import slts_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_WORDS = 120;

  localparam int RX_OPEN    = 0;
  localparam int RX_CHOPPY  = 1;
  localparam int RX_CLOGGED = 2;
  localparam int RX_SHUT    = 3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_ready;
  logic [7:0]           char_byte = 8'h00;
  logic                 has_byte = 1'b0;
  logic                 end_of_source = 1'b0;
  logic                 token_valid;
  logic                 token_ready = 1'b0;
  logic [KIND_W-1:0]    token_kind;
  logic [15:0]          token_start;
  logic [15:0]          token_length;
  logic [15:0]          token_line;
  logic                 last_of_run;
  int                   mismatch_count;
  int                   tokens_pending;

  int                   cycles = 0;
  int                   words_sent = 0;
  int                   burst_left = 0;
  int                   rx_style = RX_OPEN;
  int                   rx_left = 0;

  string                letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string                digits = "0123456789";
  string                ops = "(){},.-+;*!=<>/";
  logic [7:0]           blank [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  source_lexer_token_scanner_unit uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .char_byte(char_byte),
    .has_byte(has_byte),
    .end_of_source(end_of_source),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .token_line(token_line),
    .last_of_run(last_of_run)
  );

  lexer_token_monitor monitor (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .char_byte(char_byte),
    .has_byte(has_byte),
    .end_of_source(end_of_source),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .token_line(token_line),
    .last_of_run(last_of_run),
    .mismatch_count(mismatch_count),
    .tokens_pending(tokens_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_source_lexer_token_scanner_unit NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(RX_OPEN, RX_SHUT);
      rx_left = $urandom_range(1, 20);
    end else begin
      rx_left--;
    end
    case (rx_style)
      RX_OPEN:    token_ready <= 1'b1;
      RX_CHOPPY:  token_ready <= 1'($urandom_range(0, 1));
      RX_CLOGGED: token_ready <= ($urandom_range(0, 3) == 0);
      default:    token_ready <= 1'b0;
    endcase
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic send_word(input logic [7:0] c, input logic hb, input logic eos);
    byte_valid <= 1'b1;
    char_byte <= c;
    has_byte <= hb;
    end_of_source <= eos;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    words_sent++;
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, 1'b0);
  endtask

  initial begin : stimulus
    int random_floor;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every operator, then an empty marker and a bad byte closing the source
    send_text("(){},.-+;*!!=<<=>>===/");
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    // fraction, trailing dot, comment, multi-line string, unterminated string
    send_text("9.5 7.;x1//c\n\"a\n\"");
    send_word(CH_QUOTE, 1'b1, 1'b0);
    send_word(8'h80, 1'b0, 1'b1);

    send_text("ab1.x");
    send_word(CH_QUOTE, 1'b1, 1'b1);

    random_floor = words_sent + RANDOM_WORDS;
    while (words_sent < random_floor) begin
      case ($urandom_range(0, 15))
        0, 1, 2: begin
          send_word(pick(ops), 1'b1, 1'b0);
          if ($urandom_range(0, 1)) send_word("=", 1'b1, 1'b0);
        end
        3, 4, 14: begin
          send_word(pick(letters), 1'b1, 1'b0);
          repeat ($urandom_range(0, 4)) send_word(pick({letters, digits}), 1'b1, 1'b0);
        end
        5, 6, 15: begin
          repeat ($urandom_range(1, 3)) send_word(pick(digits), 1'b1, 1'b0);
          if ($urandom_range(0, 1)) begin
            send_word(".", 1'b1, 1'b0);
            repeat ($urandom_range(0, 2)) send_word(pick(digits), 1'b1, 1'b0);
          end
        end
        7: begin
          send_word(CH_QUOTE, 1'b1, 1'b0);
          repeat ($urandom_range(0, 5)) send_word(pick({letters, " +1\n"}), 1'b1, 1'b0);
          if ($urandom_range(0, 9) != 0) send_word(CH_QUOTE, 1'b1, 1'b0);
        end
        8: begin
          send_text("//");
          repeat ($urandom_range(0, 4)) send_word(pick({letters, ops}), 1'b1, 1'b0);
          send_word(CH_LF, 1'b1, 1'b0);
        end
        9, 10: send_word(blank[$urandom_range(0, 3)], 1'b1, 1'b0);
        11: send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        12: send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        default: send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      endcase
    end
    send_word(pick(digits), 1'b1, 1'b1);
    byte_valid <= 1'b0;

    // drain the token queue, then hold for late strays
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && tokens_pending == 0) begin
      $display("tb_source_lexer_token_scanner_unit OK");
    end else begin
      $display("tb_source_lexer_token_scanner_unit NOT OK");
    end
    $finish;
  end

endmodule
